[hw/rtl/kwc_pkg.sv]
`timescale 1ns / 1ps
package kwc_pkg;

	// Alphabet and byte constants
	localparam int unsigned LETTERS = 26;
	localparam int unsigned IDX_W = 5;
	localparam logic [7:0] CHAR_A = 8'd97;
	localparam logic [7:0] CHAR_Z = 8'd122;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LETTERS - 1);

	// Request codes
	localparam logic [1:0] REQ_KEY = 2'd0;
	localparam logic [1:0] REQ_FIN = 2'd1;
	localparam logic [1:0] REQ_TEXT = 2'd2;

	// Program steps
	localparam int unsigned STEP_W = 3;
	localparam logic [STEP_W-1:0] S_FETCH = 3'd0;
	localparam logic [STEP_W-1:0] S_KEY = 3'd1;
	localparam logic [STEP_W-1:0] S_FIN_INIT = 3'd2;
	localparam logic [STEP_W-1:0] S_FIN_LOOP = 3'd3;
	localparam logic [STEP_W-1:0] S_FIN_DONE = 3'd4;
	localparam logic [STEP_W-1:0] S_TEXT_RD = 3'd5;
	localparam logic [STEP_W-1:0] S_TEXT_OUT = 3'd6;

	// Datapath operations
	localparam logic [2:0] OP_NONE = 3'd0;
	localparam logic [2:0] OP_APPEND = 3'd1;
	localparam logic [2:0] OP_KINIT = 3'd2;
	localparam logic [2:0] OP_FILL = 3'd3;
	localparam logic [2:0] OP_CLOSE = 3'd4;
	localparam logic [2:0] OP_READ = 3'd5;
	localparam logic [2:0] OP_EMIT = 3'd6;

	// Jump conditions
	localparam logic [2:0] JC_NEXT = 3'd0;
	localparam logic [2:0] JC_GOTO = 3'd1;
	localparam logic [2:0] JC_DISPATCH = 3'd2;
	localparam logic [2:0] JC_KZERO = 3'd3;
	localparam logic [2:0] JC_OUTFREE = 3'd4;

	typedef struct packed {
		logic in_ready;
		logic [2:0] op;
		logic [2:0] jc;
		logic [STEP_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic [1:0] req;
		logic k_zero;
		logic out_free;
	} stat_t;

	// Control store: one word per step
	function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
		ctrl_t cw;
		cw = '{in_ready: 1'b0, op: OP_NONE, jc: JC_GOTO, target: S_FETCH};
		case (step)
			S_FETCH: cw = '{in_ready: 1'b1, op: OP_NONE, jc: JC_DISPATCH, target: S_FETCH};
			S_KEY: cw = '{in_ready: 1'b0, op: OP_APPEND, jc: JC_GOTO, target: S_FETCH};
			S_FIN_INIT: cw = '{in_ready: 1'b0, op: OP_KINIT, jc: JC_NEXT, target: S_FETCH};
			S_FIN_LOOP: cw = '{in_ready: 1'b0, op: OP_FILL, jc: JC_KZERO, target: S_FIN_DONE};
			S_FIN_DONE: cw = '{in_ready: 1'b0, op: OP_CLOSE, jc: JC_GOTO, target: S_FETCH};
			S_TEXT_RD: cw = '{in_ready: 1'b0, op: OP_READ, jc: JC_NEXT, target: S_FETCH};
			S_TEXT_OUT: cw = '{in_ready: 1'b0, op: OP_EMIT, jc: JC_OUTFREE, target: S_FETCH};
			default: cw = '{in_ready: 1'b0, op: OP_NONE, jc: JC_GOTO, target: S_FETCH};
		endcase
		return cw;
	endfunction

endpackage

[hw/rtl/kwc_ifs.sv]
`timescale 1ns / 1ps
interface kwc_req_if;
	logic valid;
	logic ready;
	logic [1:0] req_type;
	logic [7:0] data_byte;

	modport source (output valid, output req_type, output data_byte, input ready);
	modport sink (input valid, input req_type, input data_byte, output ready);
endinterface

interface kwc_res_if;
	logic valid;
	logic ready;
	logic [7:0] cipher_byte;

	modport source (output valid, output cipher_byte, input ready);
	modport sink (input valid, input cipher_byte, output ready);
endinterface

[hw/rtl/keyword_substitution_cipher.sv]
`timescale 1ns / 1ps
// Keyword substitution cipher.
// request channel (sink): req_type 0 appends a keyword byte, 1 finalizes the
// cipher alphabet, 2 enciphers data_byte; code 3 is taken and dropped.
// result channel (source): one cipher_byte for each plaintext item only.
// A small control program sequences the datapath, one item at a time.
// Keyword bytes take a fetch and an append step, plaintext a fetch, a table
// read and an emit step; a finalize takes a fetch and a setup step, walks the
// 26 letters from z down to a in the fill walk, and ends with a close step.
// The plaintext table read is registered before the emit step loads the result.
// Results sit in an output register; the next item is taken while a result
// waits. A plaintext item whose result finds the register still full holds
// its last step until the receiver takes the earlier result.
// Reset clears the letter record, fill count and ready flag; text then passes
// unchanged until the first finalize. The table memory is not cleared: every
// slot is written before it can be read.
module keyword_substitution_cipher (
	input logic clk,
	input logic arst_n,
	kwc_req_if.sink request,
	kwc_res_if.source result
);
	import kwc_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	logic [7:0] byte_q;
	logic [LETTERS-1:0] letter_used_q;
	logic [IDX_W-1:0] fill_q;
	logic [IDX_W-1:0] k_q;
	logic table_ready_q;
	logic out_valid_q;
	logic [7:0] out_byte_q;

	logic accept;
	logic is_letter;
	logic [7:0] offset;
	logic [IDX_W-1:0] idx;
	logic has_room;
	logic out_free;
	logic do_append;
	logic do_fill;
	logic wr_en;
	logic [IDX_W-1:0] wr_data;
	logic [IDX_W-1:0] rd_data;
	logic [IDX_W-1:0] sub_idx;
	logic [7:0] emit_byte;

	kwc_seq u_seq (
		.clk (clk),
		.arst_n (arst_n),
		.stat (stat),
		.ctrl (ctrl)
	);

	assign request.ready = ctrl.in_ready;
	assign accept = request.valid && ctrl.in_ready;

	assign out_free = !out_valid_q || result.ready;
	assign stat = '{in_valid: request.valid, req: request.req_type,
		k_zero: (k_q == '0), out_free: out_free};

	// Decode the held byte
	assign is_letter = (byte_q >= CHAR_A) && (byte_q <= CHAR_Z);
	assign offset = byte_q - CHAR_A;
	assign idx = offset[IDX_W-1:0];
	assign has_room = (fill_q < IDX_W'(LETTERS));

	assign do_append = (ctrl.op == OP_APPEND) && is_letter && has_room && !letter_used_q[idx];
	assign do_fill = (ctrl.op == OP_FILL) && has_room && !letter_used_q[k_q];
	assign wr_en = do_append || do_fill;
	assign wr_data = do_append ? idx : k_q;

	kwc_ram #(
		.WIDTH (IDX_W),
		.DEPTH (LETTERS)
	) u_table (
		.clk (clk),
		.wr_en (wr_en),
		.wr_addr (fill_q),
		.wr_data (wr_data),
		.rd_addr (idx),
		.rd_data (rd_data)
	);

	// Clamp the table entry and form the substituted letter
	assign sub_idx = (rd_data >= IDX_W'(LETTERS)) ? LAST_IDX : rd_data;
	assign emit_byte = (is_letter && table_ready_q) ? (CHAR_A + {3'b000, sub_idx}) : byte_q;

	// Hold the accepted byte
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= request.data_byte;
		end
	end

	// Keyword record, fill pointer and walk counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			letter_used_q <= '0;
			fill_q <= '0;
			k_q <= '0;
			table_ready_q <= 1'b0;
		end else begin
			case (ctrl.op)
				OP_APPEND: begin
					if (do_append) begin
						letter_used_q[idx] <= 1'b1;
						fill_q <= fill_q + IDX_W'(1);
						table_ready_q <= 1'b0;
					end
				end
				OP_KINIT: k_q <= LAST_IDX;
				OP_FILL: begin
					if (do_fill) begin
						fill_q <= fill_q + IDX_W'(1);
					end
					k_q <= k_q - IDX_W'(1);
				end
				OP_CLOSE: begin
					letter_used_q <= '0;
					fill_q <= '0;
					table_ready_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Output register: load on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((ctrl.op == OP_EMIT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((ctrl.op == OP_EMIT) && out_free) begin
			out_byte_q <= emit_byte;
		end
	end

	assign result.valid = out_valid_q;
	assign result.cipher_byte = out_byte_q;

	// Checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= IDX_W'(LETTERS))
		else $error("fill pointer past end of alphabet");

	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.op == OP_CLOSE |=> fill_q == '0 && table_ready_q && letter_used_q == '0)
		else $error("finalize did not reset keyword state");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.in_ready |-> $countones(letter_used_q) == int'(fill_q))
		else $error("letter record disagrees with fill pointer");

	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctrl.op == OP_EMIT))
		else $error("result raised outside emit step");

endmodule

[hw/rtl/kwc_ram.sv]
`timescale 1ns / 1ps
module kwc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input logic clk,
	input logic wr_en,
	input logic [$clog2(DEPTH)-1:0] wr_addr,
	input logic [WIDTH-1:0] wr_data,
	input logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write one entry, register the read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

[hw/rtl/kwc_seq.sv]
`timescale 1ns / 1ps
module kwc_seq (
	input logic clk,
	input logic arst_n,
	input kwc_pkg::stat_t stat,
	output kwc_pkg::ctrl_t ctrl
);
	import kwc_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_next;
	ctrl_t cw;

	assign cw = ucode(step_q);
	assign ctrl = cw;

	// Pick the next step from the jump field
	always_comb begin
		step_next = S_FETCH;
		case (cw.jc)
			JC_NEXT: step_next = step_q + STEP_W'(1);
			JC_GOTO: step_next = cw.target;
			JC_DISPATCH: begin
				if (stat.in_valid) begin
					case (stat.req)
						REQ_KEY: step_next = S_KEY;
						REQ_FIN: step_next = S_FIN_INIT;
						REQ_TEXT: step_next = S_TEXT_RD;
						default: step_next = S_FETCH;
					endcase
				end else begin
					step_next = S_FETCH;
				end
			end
			JC_KZERO: step_next = stat.k_zero ? cw.target : step_q;
			JC_OUTFREE: step_next = stat.out_free ? cw.target : step_q;
			default: step_next = S_FETCH;
		endcase
	end

	// Advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_FETCH;
		end else begin
			step_q <= step_next;
		end
	end

endmodule
